// ----- rtl/core/program_stream_video_extractor_defines.svh -----
// Assertion macros shared by the program stream video extractor RTL.
`ifndef PROGRAM_STREAM_VIDEO_EXTRACTOR_DEFINES_SVH
`define PROGRAM_STREAM_VIDEO_EXTRACTOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PSVE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold at the clock edge after the antecedent.
`define PSVE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/psve_pkg.sv -----
// Types and constants shared by the program stream video extractor modules.
package psve_pkg;

  typedef enum logic [2:0] {
    PH_PACK,
    PH_DISPATCH,
    PH_MAP,
    PH_PES,
    PH_SKIP,
    PH_HDRSKIP,
    PH_PAYLOAD
  } psve_phase_t;

  localparam logic [3:0]  PACK_HDR_LAST   = 4'd13;
  localparam logic [3:0]  START_CODE_LEN  = 4'd3;
  localparam logic [3:0]  START_CODE_LAST = 4'd2;
  localparam logic [3:0]  HI_LEN_HI       = 4'd4;
  localparam logic [3:0]  HI_LEN_LO       = 4'd5;
  localparam logic [3:0]  HI_FLAGS        = 4'd6;
  localparam logic [3:0]  HI_HDR_LEN      = 4'd8;
  localparam logic [7:0]  START_BYTE_ZERO = 8'h00;
  localparam logic [7:0]  START_BYTE_ONE  = 8'h01;
  localparam logic [7:0]  MAP_ID          = 8'hBC;
  localparam logic [7:0]  STUFF_MASK      = 8'h07;
  localparam logic [7:0]  VIDEO_ID_RESET  = 8'hE0;
  localparam logic [15:0] PES_FIXED_HDR   = 16'd3;
  localparam logic [23:0] TOTAL_MAX       = 24'hFFFFFF;
  localparam int          QUEUE_DEPTH_DEFAULT = 4;

  // One classified beat handed from the parser to the output side.
  typedef struct packed {
    logic [7:0] data;
    logic       emit;
    logic       eob;
  } psve_tok_t;

endpackage

// ----- rtl/core/psve_stream_if.sv -----
// Valid/ready stream interfaces for the input bytes and the extracted results.
interface psve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface psve_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [23:0] payload_total;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output payload_total, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input last,
                input payload_total, output ready);
endinterface

// ----- rtl/core/psve_front.sv -----
// Stream parser: walks pack headers, map packets and PES headers, tags payload beats.
`include "program_stream_video_extractor_defines.svh"

module psve_front (
  input  logic               clk,
  input  logic               rst_n,
  psve_in_if.sink            in_bus,
  input  logic [7:0]         video_id,
  output logic               push_valid,
  input  logic               push_ready,
  output psve_pkg::psve_tok_t push_tok
);

  psve_pkg::psve_phase_t phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] pay_r, pay_nxt;
  logic        emit;
  logic        accept;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] room;
  logic [15:0] dec;
  logic [15:0] stuff;

  assign b      = in_bus.in_byte;
  assign accept = in_bus.valid && in_bus.ready;

  assign in_bus.ready = push_ready;
  assign push_valid   = in_bus.valid && (emit || in_bus.end_of_buffer);
  assign push_tok     = '{data: b, emit: emit, eob: in_bus.end_of_buffer};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= psve_pkg::PH_PACK;
      hidx_r  <= '0;
      plen_r  <= '0;
      skip_r  <= '0;
      pay_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      plen_r  <= plen_nxt;
      skip_r  <= skip_nxt;
      pay_r   <= pay_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    plen_nxt  = plen_r;
    skip_nxt  = skip_r;
    pay_nxt   = pay_r;
    emit      = 1'b0;
    len       = {plen_r[15:8], b};
    room      = plen_r - psve_pkg::PES_FIXED_HDR;
    dec       = (skip_r != '0) ? skip_r - 16'd1 : skip_r;
    stuff     = {8'h00, b & psve_pkg::STUFF_MASK};

    case (phase_r)
      psve_pkg::PH_PACK: begin
        if (hidx_r >= psve_pkg::PACK_HDR_LAST) begin
          if (stuff == '0) begin
            phase_nxt = psve_pkg::PH_DISPATCH;
            hidx_nxt  = '0;
          end else begin
            skip_nxt  = stuff;
            phase_nxt = psve_pkg::PH_SKIP;
          end
        end else begin
          hidx_nxt = hidx_r + 4'd1;
        end
      end
      psve_pkg::PH_DISPATCH: begin
        if (hidx_r < psve_pkg::START_CODE_LEN) begin
          hidx_nxt = hidx_r + 4'd1;
          // The index keeps counting when the start code breaks off, so the
          // fallback pack header is shortened by the bytes already seen.
          if (b != ((hidx_r == psve_pkg::START_CODE_LAST) ? psve_pkg::START_BYTE_ONE
                                                          : psve_pkg::START_BYTE_ZERO)) begin
            phase_nxt = psve_pkg::PH_PACK;
          end
        end else begin
          hidx_nxt = psve_pkg::HI_LEN_HI;
          if (b == video_id) begin
            phase_nxt = psve_pkg::PH_PES;
          end else if (b == psve_pkg::MAP_ID) begin
            phase_nxt = psve_pkg::PH_MAP;
          end else begin
            phase_nxt = psve_pkg::PH_PACK;
          end
        end
      end
      psve_pkg::PH_MAP: begin
        if (hidx_r == psve_pkg::HI_LEN_HI) begin
          plen_nxt = {b, 8'h00};
          hidx_nxt = psve_pkg::HI_LEN_LO;
        end else begin
          plen_nxt = len;
          if (len == '0) begin
            phase_nxt = psve_pkg::PH_DISPATCH;
            hidx_nxt  = '0;
          end else begin
            skip_nxt  = len;
            phase_nxt = psve_pkg::PH_SKIP;
          end
        end
      end
      psve_pkg::PH_PES: begin
        if (hidx_r == psve_pkg::HI_LEN_HI) begin
          plen_nxt = {b, 8'h00};
          hidx_nxt = psve_pkg::HI_LEN_LO;
        end else if (hidx_r == psve_pkg::HI_LEN_LO) begin
          plen_nxt = len;
          if (len < psve_pkg::PES_FIXED_HDR) begin
            if (len == '0) begin
              phase_nxt = psve_pkg::PH_DISPATCH;
              hidx_nxt  = '0;
            end else begin
              skip_nxt  = len;
              phase_nxt = psve_pkg::PH_SKIP;
            end
          end else begin
            hidx_nxt = psve_pkg::HI_FLAGS;
          end
        end else if (hidx_r < psve_pkg::HI_HDR_LEN) begin
          hidx_nxt = hidx_r + 4'd1;
        end else if ({8'h00, b} > room) begin
          // Header data overruns the packet: skip the rest, no payload.
          pay_nxt = '0;
          if (room == '0) begin
            phase_nxt = psve_pkg::PH_DISPATCH;
            hidx_nxt  = '0;
          end else begin
            skip_nxt  = room;
            phase_nxt = psve_pkg::PH_SKIP;
          end
        end else begin
          pay_nxt = room - {8'h00, b};
          if (b != 8'h00) begin
            skip_nxt  = {8'h00, b};
            phase_nxt = psve_pkg::PH_HDRSKIP;
          end else if (room == {8'h00, b}) begin
            phase_nxt = psve_pkg::PH_DISPATCH;
            hidx_nxt  = '0;
          end else begin
            phase_nxt = psve_pkg::PH_PAYLOAD;
          end
        end
      end
      psve_pkg::PH_SKIP: begin
        skip_nxt = dec;
        if (dec == '0) begin
          phase_nxt = psve_pkg::PH_DISPATCH;
          hidx_nxt  = '0;
        end
      end
      psve_pkg::PH_HDRSKIP: begin
        skip_nxt = dec;
        if (dec == '0) begin
          if (pay_r == '0) begin
            phase_nxt = psve_pkg::PH_DISPATCH;
            hidx_nxt  = '0;
          end else begin
            phase_nxt = psve_pkg::PH_PAYLOAD;
          end
        end
      end
      psve_pkg::PH_PAYLOAD: begin
        emit    = 1'b1;
        pay_nxt = (pay_r != '0) ? pay_r - 16'd1 : pay_r;
        if (pay_nxt == '0) begin
          phase_nxt = psve_pkg::PH_DISPATCH;
          hidx_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = psve_pkg::PH_PACK;
        hidx_nxt  = '0;
        plen_nxt  = '0;
        skip_nxt  = '0;
        pay_nxt   = '0;
      end
    endcase

    // The last byte of a buffer returns the parser to its starting point.
    if (in_bus.end_of_buffer) begin
      phase_nxt = psve_pkg::PH_PACK;
      hidx_nxt  = '0;
      plen_nxt  = '0;
      skip_nxt  = '0;
      pay_nxt   = '0;
    end
  end

  `PSVE_ASSERT_ALWAYS(a_payload_left,
    (phase_r != psve_pkg::PH_PAYLOAD) || (pay_r != '0), "payload phase with nothing left")
  `PSVE_ASSERT_ALWAYS(a_skip_left,
    ((phase_r != psve_pkg::PH_SKIP) && (phase_r != psve_pkg::PH_HDRSKIP)) || (skip_r != '0),
    "skip phase with zero count")

endmodule

// ----- rtl/core/psve_queue.sv -----
// Small FIFO that decouples the parser from the output stage.
`include "program_stream_video_extractor_defines.svh"

module psve_queue #(
  parameter int DEPTH = psve_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  psve_pkg::psve_tok_t push_tok,
  output logic                pop_valid,
  input  logic                pop_ready,
  output psve_pkg::psve_tok_t pop_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  psve_pkg::psve_tok_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_tok    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  `PSVE_ASSERT_ALWAYS(a_q_bound, cnt_r <= CNT_FULL, "queue count beyond depth")

endmodule

// ----- rtl/core/psve_back.sv -----
// Output stage: counts payload per buffer and holds the result beat for the sink.
`include "program_stream_video_extractor_defines.svh"

module psve_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  psve_pkg::psve_tok_t pop_tok,
  psve_out_if.source          out_bus
);

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_bvalid_r;
  logic        out_last_r;
  logic [23:0] out_total_r;
  logic [23:0] count_r;
  logic [23:0] count_inc;
  logic        pop;

  assign pop_ready = !out_valid_r || out_bus.ready;
  assign pop       = pop_valid && pop_ready;
  assign count_inc = (pop_tok.emit && (count_r != psve_pkg::TOTAL_MAX))
                     ? count_r + 24'd1 : count_r;

  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_byte      = out_byte_r;
  assign out_bus.byte_valid    = out_bvalid_r;
  assign out_bus.last          = out_last_r;
  assign out_bus.payload_total = out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        // The running total starts over after the buffer's last beat.
        count_r     <= pop_tok.eob ? '0 : count_inc;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r   <= pop_tok.emit ? pop_tok.data : 8'h00;
      out_bvalid_r <= pop_tok.emit;
      out_last_r   <= pop_tok.eob;
      out_total_r  <= count_inc;
    end
  end

  `PSVE_ASSERT_NEXT(a_eob_clears, pop && pop_tok.eob, count_r == '0, "total not cleared after buffer end")
  `PSVE_ASSERT_ALWAYS(a_total_nonzero, !(out_valid_r && out_bvalid_r) || (out_total_r != '0), "payload beat with zero total")

endmodule

// ----- rtl/core/program_stream_video_extractor.sv -----
// Top level of the program stream video extractor.
// Takes one program stream byte per cycle while the FIFO has room and
// returns the payload bytes of PES packets whose stream id matches
// cfg_wr_data as last written (0xE0 after reset), plus a beat for the
// buffer's last byte that is a bare marker when that byte is not payload.
// The parser settles each byte in the cycle it is accepted, so input beats
// are taken back to back; a QUEUE_DEPTH-entry FIFO and an output register
// let the result side stall without holding up the parser until the FIFO
// fills. A result passes through a FIFO slot and the output register in turn.
// Configuration may only be written while no beat is in flight.
module program_stream_video_extractor #(
  parameter int QUEUE_DEPTH = psve_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  psve_in_if.sink     in_bus,
  psve_out_if.source  out_bus,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0]          video_id_r;
  logic                push_valid, push_ready;
  psve_pkg::psve_tok_t push_tok;
  logic                pop_valid, pop_ready;
  psve_pkg::psve_tok_t pop_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_id_r <= psve_pkg::VIDEO_ID_RESET;
    end else if (cfg_wr_en) begin
      video_id_r <= cfg_wr_data;
    end
  end

  psve_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .video_id   (video_id_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok)
  );

  psve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tok    (pop_tok)
  );

  psve_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_tok   (pop_tok),
    .out_bus   (out_bus)
  );

endmodule

// ----- verif/tb_program_stream_video_extractor.sv -----
// Self-checking testbench for the program stream video payload extractor.
`timescale 1ns / 1ps

module tb_program_stream_video_extractor;

  localparam logic [7:0] PACK_CODE     = 8'hBA;
  localparam logic [7:0] ALT_PACK_CODE = 8'hBB;
  localparam logic [7:0] AUDIO_ID      = 8'hC0;
  localparam logic [7:0] PES_FLAGS_0   = 8'h81;
  localparam logic [7:0] PES_FLAGS_1   = 8'h80;
  localparam logic [7:0] STUFF_BYTE    = 8'hFF;
  localparam int         QUIET_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0]  data;
    logic        is_payload;
    logic        is_last;
    logic [23:0] total;
  } video_beat_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  psve_in_if  in_bus ();
  psve_out_if out_bus ();

  program_stream_video_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Parser mirror state.
  logic [7:0]            video_id;
  psve_pkg::psve_phase_t phase;
  logic [3:0]            hdr_idx;
  logic [15:0]           pkt_len;
  logic [16:0]           skip_cnt;
  logic [15:0]           pay_left;
  logic [23:0]           pay_total;

  video_beat_t beats_due[$];
  video_beat_t got_due;
  logic [7:0]  stream_q[$];
  int          mismatches;
  int          sent_bytes;
  int          quiet_cycles;
  int          rx_hold;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic void clear_parser();
    phase     = psve_pkg::PH_PACK;
    hdr_idx   = '0;
    pkt_len   = '0;
    skip_cnt  = '0;
    pay_left  = '0;
    pay_total = '0;
  endfunction

  function automatic void go_dispatch();
    phase   = psve_pkg::PH_DISPATCH;
    hdr_idx = '0;
  endfunction

  function automatic void skip_to_dispatch(input logic [16:0] n);
    if (n == 0) begin
      go_dispatch();
    end else begin
      skip_cnt = n;
      phase    = psve_pkg::PH_SKIP;
    end
  endfunction

  function automatic void begin_payload();
    if (pay_left == 0) go_dispatch();
    else phase = psve_pkg::PH_PAYLOAD;
  endfunction

  function automatic void track_stream_byte(input logic [7:0] b, input logic eob);
    logic        emit;
    logic [15:0] room;
    video_beat_t beat;
    emit = 1'b0;
    case (phase)
      psve_pkg::PH_PACK: begin
        if (hdr_idx >= psve_pkg::PACK_HDR_LAST) skip_to_dispatch({14'd0, b[2:0]});
        else hdr_idx++;
      end
      psve_pkg::PH_DISPATCH: begin
        if (hdr_idx < psve_pkg::START_CODE_LEN) begin
          if (b != ((hdr_idx == psve_pkg::START_CODE_LAST) ? psve_pkg::START_BYTE_ONE
                                                           : psve_pkg::START_BYTE_ZERO))
            phase = psve_pkg::PH_PACK;
          hdr_idx++;
        end else begin
          hdr_idx = psve_pkg::HI_LEN_HI;
          // The video test comes first, so an id equal to the map code is video.
          if (b == video_id) phase = psve_pkg::PH_PES;
          else if (b == psve_pkg::MAP_ID) phase = psve_pkg::PH_MAP;
          else phase = psve_pkg::PH_PACK;
        end
      end
      psve_pkg::PH_MAP: begin
        if (hdr_idx == psve_pkg::HI_LEN_HI) begin
          pkt_len = {b, 8'h00};
          hdr_idx = psve_pkg::HI_LEN_LO;
        end else begin
          pkt_len = pkt_len | {8'h00, b};
          skip_to_dispatch({1'b0, pkt_len});
        end
      end
      psve_pkg::PH_PES: begin
        if (hdr_idx == psve_pkg::HI_LEN_HI) begin
          pkt_len = {b, 8'h00};
          hdr_idx = psve_pkg::HI_LEN_LO;
        end else if (hdr_idx == psve_pkg::HI_LEN_LO) begin
          pkt_len = pkt_len | {8'h00, b};
          if (pkt_len < 16'd3) skip_to_dispatch({1'b0, pkt_len});
          else hdr_idx = psve_pkg::HI_FLAGS;
        end else if (hdr_idx < psve_pkg::HI_HDR_LEN) begin
          hdr_idx++;
        end else begin
          room = pkt_len - 16'd3;
          if ({8'h00, b} > room) begin
            pay_left = '0;
            skip_to_dispatch({1'b0, room});
          end else begin
            pay_left = room - {8'h00, b};
            if (b == 0) begin
              begin_payload();
            end else begin
              skip_cnt = {9'd0, b};
              phase    = psve_pkg::PH_HDRSKIP;
            end
          end
        end
      end
      psve_pkg::PH_SKIP: begin
        if (skip_cnt > 0) skip_cnt--;
        if (skip_cnt == 0) go_dispatch();
      end
      psve_pkg::PH_HDRSKIP: begin
        if (skip_cnt > 0) skip_cnt--;
        if (skip_cnt == 0) begin_payload();
      end
      psve_pkg::PH_PAYLOAD: begin
        emit = 1'b1;
        if (pay_total < psve_pkg::TOTAL_MAX) pay_total++;
        if (pay_left > 0) pay_left--;
        if (pay_left == 0) go_dispatch();
      end
      default: clear_parser();
    endcase
    if (emit || eob) begin
      beat.data       = emit ? b : 8'h00;
      beat.is_payload = emit;
      beat.is_last    = eob;
      beat.total      = pay_total;
      beats_due.push_back(beat);
    end
    if (eob) clear_parser();
  endfunction

  // ---------------------------------------------------------- monitor, checks
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (beats_due.size() == 0) begin
          report_mismatch("unexpected result beat, out_byte", 32'(out_bus.out_byte), 32'd0);
        end else begin
          got_due = beats_due.pop_front();
          if (out_bus.out_byte !== got_due.data)
            report_mismatch("out_byte", 32'(out_bus.out_byte), 32'(got_due.data));
          if (out_bus.byte_valid !== got_due.is_payload)
            report_mismatch("byte_valid", 32'(out_bus.byte_valid), 32'(got_due.is_payload));
          if (out_bus.last !== got_due.is_last)
            report_mismatch("last", 32'(out_bus.last), 32'(got_due.is_last));
          if (out_bus.payload_total !== got_due.total)
            report_mismatch("payload_total", 32'(out_bus.payload_total),
                            32'(got_due.total));
        end
      end
      if (in_bus.valid && in_bus.ready)
        track_stream_byte(in_bus.in_byte, in_bus.end_of_buffer);
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side stalls at random, in bursts.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      out_bus.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      rx_hold       <= $urandom_range(0, 7);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------ driving
  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.in_byte       <= b;
    in_bus.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Holds the input back until every predicted beat has come out.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_stream_id(input logic [7:0] id);
    drain_results();
    // Bytes that cause no beat never enter the FIFO; the parser settles them when accepted.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    video_id = id;
  endtask

  task automatic send_stream(input bit mark_end);
    int n;
    int i;
    n = stream_q.size();
    for (i = 0; i < n; i++) begin
      if (!calm && $urandom_range(0, 299) == 0) drain_results();
      send_byte(stream_q[i], mark_end && (i == n - 1));
    end
    stream_q.delete();
  endtask

  // ------------------------------------------------------- stream assembly
  function automatic void add_random(input int n);
    int i;
    for (i = 0; i < n; i++) stream_q.push_back(8'($urandom));
  endfunction

  function automatic void add_start_code(input logic [7:0] id);
    stream_q.push_back(psve_pkg::START_BYTE_ZERO);
    stream_q.push_back(psve_pkg::START_BYTE_ZERO);
    stream_q.push_back(psve_pkg::START_BYTE_ONE);
    stream_q.push_back(id);
  endfunction

  // Pack header is 14 bytes plus its stuffing, whether it opens the buffer or follows a unit.
  function automatic void add_pack(input int stuff);
    logic [7:0] tail;
    int i;
    add_start_code((video_id == PACK_CODE) ? ALT_PACK_CODE : PACK_CODE);
    add_random(9);
    tail = 8'($urandom);
    tail[2:0] = 3'(stuff);
    stream_q.push_back(tail);
    for (i = 0; i < stuff; i++) stream_q.push_back(STUFF_BYTE);
  endfunction

  function automatic void add_pes_head(input logic [15:0] len, input logic [7:0] hdr);
    add_start_code(video_id);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    if (len >= 16'd3) begin
      stream_q.push_back(PES_FLAGS_0);
      stream_q.push_back(PES_FLAGS_1);
      stream_q.push_back(hdr);
    end
  endfunction

  function automatic void add_pes(input int len, input int hdr);
    add_pes_head(16'(len), 8'(hdr));
    add_random((len < 3) ? len : len - 3);
  endfunction

  function automatic void add_map(input int len);
    add_start_code(psve_pkg::MAP_ID);
    stream_q.push_back(8'(len >> 8));
    stream_q.push_back(8'(len));
    add_random(len);
  endfunction

  task automatic random_buffer();
    int units;
    int u;
    int r;
    int len;
    int hdr;
    int keep;
    add_pack($urandom_range(0, 7));
    units = $urandom_range(1, 6);
    for (u = 0; u < units; u++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = $urandom_range(3, 40);
        if ($urandom_range(0, 39) == 0) len = $urandom_range(200, 600);
        else if ($urandom_range(0, 11) == 0) len = $urandom_range(0, 2);
        hdr = 0;
        if (len >= 3) begin
          if ($urandom_range(0, 9) == 0) hdr = len - 3 + $urandom_range(1, 5);
          else hdr = $urandom_range(0, (len - 3 < 10) ? len - 3 : 10);
          if (hdr > 255) hdr = 255;
        end
        add_pes(len, hdr);
      end else if (r < 75) begin
        add_map($urandom_range(0, 24));
      end else if (r < 85) begin
        add_pack($urandom_range(0, 7));
      end else if (r < 92) begin
        add_start_code(AUDIO_ID);
        add_random($urandom_range(2, 20));
      end else begin
        if ($urandom_range(0, 1) == 0) stream_q.push_back(psve_pkg::START_BYTE_ZERO);
        add_random($urandom_range(1, 12));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_stream(1'b0);
    end else begin
      if (r < 30) begin
        keep = $urandom_range(1, stream_q.size());
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
      send_stream(1'b1);
    end
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_default_id();
    add_pack(0);
    add_pes(8, 2);
    add_map(0);
    add_pes(3, 0);
    add_pack(7);
    add_map(5);
    add_start_code(AUDIO_ID);
    add_random(10);
    add_pes(6, 0);
    send_stream(1'b1);
  endtask

  task automatic test_odd_pes_lengths();
    add_pack(1);
    add_pes(0, 0);
    add_pes(1, 0);
    add_pes(2, 0);
    add_pes(5, 3);
    add_pes(9, 6);
    add_pes(4, 0);
    send_stream(1'b1);
  endtask

  task automatic test_buffer_end();
    // A maximal packet cut after a few payload bytes.
    add_pack(2);
    add_pes_head(16'hFFFF, 8'h00);
    add_random(5);
    send_stream(1'b1);
    // End of buffer inside a pack header gives a bare marker.
    add_random(6);
    send_stream(1'b1);
    stream_q.push_back(STUFF_BYTE);
    send_stream(1'b1);
  endtask

  task automatic test_map_code_as_video();
    write_stream_id(psve_pkg::MAP_ID);
    add_pack(3);
    add_pes(10, 1);
    add_pes(2, 0);
    send_stream(1'b1);
  endtask

  task automatic test_id_extremes();
    write_stream_id(8'h00);
    add_pack(0);
    add_pes(7, 0);
    add_map(3);
    send_stream(1'b1);
    write_stream_id(8'hFF);
    add_pack(0);
    add_pes(7, 1);
    send_stream(1'b1);
  endtask

  task automatic test_random_streams(input int target);
    int stop_at;
    int next_cfg;
    int pick;
    stop_at  = sent_bytes + target;
    next_cfg = sent_bytes + 250;
    write_stream_id(psve_pkg::VIDEO_ID_RESET);
    while (sent_bytes < stop_at) begin
      if (sent_bytes >= next_cfg) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: write_stream_id(psve_pkg::VIDEO_ID_RESET);
          1: write_stream_id(psve_pkg::MAP_ID);
          2: write_stream_id(8'h00);
          3: write_stream_id(8'hFF);
          default: write_stream_id(8'($urandom));
        endcase
        next_cfg = sent_bytes + 250;
      end
      random_buffer();
    end
  endtask

  task automatic test_steady_tail(input int target);
    int stop_at;
    write_stream_id(psve_pkg::VIDEO_ID_RESET);
    calm    = 1'b1;
    stop_at = sent_bytes + target;
    while (sent_bytes < stop_at) random_buffer();
  endtask

  initial begin
    in_bus.valid         = 1'b0;
    in_bus.in_byte       = '0;
    in_bus.end_of_buffer = 1'b0;
    out_bus.ready        = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    rst_n                = 1'b0;
    calm                 = 1'b0;
    mismatches           = 0;
    sent_bytes           = 0;
    quiet_cycles         = 0;
    rx_hold              = 0;
    video_id             = psve_pkg::VIDEO_ID_RESET;
    clear_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_id();
    test_odd_pes_lengths();
    test_buffer_end();
    test_map_code_as_video();
    test_id_extremes();
    test_random_streams(600);
    test_steady_tail(150);

    drain_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
